// File: rtl/core/sot_pkg.sv
// Shared types and constants for the spectral onset edge timer.
// Used by spectral_onset_edge_timer; no other dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sot_pkg;

  localparam int unsigned BIN_COUNT = 128;
  localparam int unsigned IDX_W     = $clog2(BIN_COUNT);

  // Configuration port
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  localparam logic REG_EMA_GAIN = 1'b0;
  localparam logic REG_EPSILON  = 1'b1;

  localparam logic [15:0] EMA_GAIN_RST = 16'd655;
  localparam logic [23:0] EPSILON_RST  = 24'd6554;

  // Edge codes
  localparam logic EDGE_RISE = 1'b0;
  localparam logic EDGE_FALL = 1'b1;

  typedef struct packed {
    logic [23:0] magnitude;
    logic        last_bin;
    logic [31:0] time_ms;
  } sot_in_t;

  typedef struct packed {
    logic        edge_kind;
    logic [31:0] duration_ms;
  } sot_out_t;

endpackage

`default_nettype wire

// File: rtl/core/spectral_onset_edge_timer.sv
// Spectral onset edge timer: per-bin moving average, signal test, edge timing.
// Depends on sot_pkg for types and constants.
// An accepted bin passes the difference, multiply and new-average stages before its result
// is written to the output register. Throughput: one bin per cycle while no result waits on a
// blocked output; a bin whose average slot is still in the difference or multiply stage stalls.
// Reset clears the configuration to its defaults, the counters and flags, and the per-slot
// valid bits, so every average reads as zero without a clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module spectral_onset_edge_timer import sot_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // input channel
  input  wire logic                 in_valid_i,
  output      logic                 in_stall_o,
  input  wire sot_in_t              in_data_i,
  // result channel
  output      logic                 out_valid_o,
  input  wire logic                 out_stall_i,
  output      sot_out_t             out_data_o,
  // configuration port
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [PADDR_W-1:0]   paddr,
  input  wire logic [PDATA_W-1:0]   pwdata,
  output      logic [PDATA_W-1:0]   prdata,
  output      logic                 pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [15:0] gain_q;
  logic [23:0] eps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= EMA_GAIN_RST;
      eps_q  <= EPSILON_RST;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_EMA_GAIN) begin
        gain_q <= pwdata[15:0];
      end else begin
        eps_q <= pwdata[23:0];
      end
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_EPSILON) ? {8'h00, eps_q} : {16'h0000, gain_q};

  // ---------------------------------------------------------------------------
  // Pipeline registers
  // ---------------------------------------------------------------------------
  logic             s1_valid_q, s2_valid_q, s3_valid_q;
  sot_in_t          s1_item_q, s2_item_q, s3_item_q;
  logic [IDX_W-1:0] s1_idx_q, s2_idx_q, s3_idx_q;
  logic [31:0]      s2_avg_q, s3_avg_q;
  logic [32:0]      s2_diff_q;
  logic [48:0]      s3_prod_q;

  logic [IDX_W-1:0] bin_idx_q;
  logic             any_exceed_q;
  logic             prev_signal_q;
  logic [31:0]      last_edge_q;

  logic             out_valid_q;
  sot_out_t         out_data_q;

  logic             adv;
  logic             hazard;
  logic             accept;
  logic             retire;

  // ---------------------------------------------------------------------------
  // Average store: one write port (retire stage), one read port (accept)
  // ---------------------------------------------------------------------------
  logic [31:0]          avg_mem [BIN_COUNT];
  logic [BIN_COUNT-1:0] avg_vld_q;
  logic [31:0]          rd_data_q;
  logic                 rd_vld_q;
  logic                 byp_q;
  logic [31:0]          byp_data_q;
  logic [31:0]          new_avg;

  always_ff @(posedge clk_i) begin
    if (retire) begin
      avg_mem[s3_idx_q] <= new_avg;
    end
    if (accept) begin
      rd_data_q  <= avg_mem[bin_idx_q];
      rd_vld_q   <= avg_vld_q[bin_idx_q];
      // forward the value being written at the same edge
      byp_q      <= retire && (s3_idx_q == bin_idx_q);
      byp_data_q <= new_avg;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_vld_q <= '0;
    end else if (retire) begin
      avg_vld_q[s3_idx_q] <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: old average and signed difference
  // ---------------------------------------------------------------------------
  logic [31:0] old_avg;
  logic [32:0] diff;

  always_comb begin
    if (byp_q) begin
      old_avg = byp_data_q;
    end else if (rd_vld_q) begin
      old_avg = rd_data_q;
    end else begin
      old_avg = '0;
    end
    diff = {1'b0, s1_item_q.magnitude, 8'h00} - {1'b0, old_avg};
  end

  // ---------------------------------------------------------------------------
  // Stage 2: scale the difference by the gain
  // ---------------------------------------------------------------------------
  logic signed [49:0] prod_full;

  assign prod_full = $signed(s2_diff_q) * $signed({1'b0, gain_q});

  // ---------------------------------------------------------------------------
  // Stage 3: new average, signal test, edge decision
  // ---------------------------------------------------------------------------
  logic [32:0] avg_sum;
  logic [32:0] threshold;
  logic        exceed;
  logic        signal;
  logic        emit;

  always_comb begin
    // arithmetic shift by 16 floors the step; the sum stays in range
    avg_sum   = {1'b0, s3_avg_q} + s3_prod_q[48:16];
    new_avg   = avg_sum[31:0];
    threshold = {1'b0, new_avg} + {1'b0, eps_q, 8'h00};
    exceed    = {1'b0, s3_item_q.magnitude, 8'h00} > threshold;
    signal    = any_exceed_q || exceed;
    emit      = s3_valid_q && s3_item_q.last_bin && (signal != prev_signal_q);
  end

  // Freeze everything only when a result must go out and the output slot is blocked.
  assign adv    = !(emit && out_valid_q && out_stall_i);
  assign hazard = (s1_valid_q && (s1_idx_q == bin_idx_q)) ||
                  (s2_valid_q && (s2_idx_q == bin_idx_q));
  assign in_stall_o = !adv || hazard;
  assign accept = in_valid_i && !in_stall_o;
  assign retire = s3_valid_q && adv;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      s2_valid_q    <= 1'b0;
      s3_valid_q    <= 1'b0;
      bin_idx_q     <= '0;
      any_exceed_q  <= 1'b0;
      prev_signal_q <= 1'b0;
      last_edge_q   <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (adv) begin
        s1_valid_q <= accept;
        s2_valid_q <= s1_valid_q;
        s3_valid_q <= s2_valid_q;
      end
      if (accept) begin
        if (in_data_i.last_bin || (bin_idx_q == IDX_W'(BIN_COUNT - 1))) begin
          bin_idx_q <= '0;
        end else begin
          bin_idx_q <= bin_idx_q + 1'b1;
        end
      end
      if (retire) begin
        if (s3_item_q.last_bin) begin
          any_exceed_q  <= 1'b0;
          prev_signal_q <= signal;
          if (emit) begin
            last_edge_q <= s3_item_q.time_ms;
          end
        end else begin
          any_exceed_q <= signal;
        end
      end
      if (retire && emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q <= in_data_i;
      s1_idx_q  <= bin_idx_q;
    end
    if (adv) begin
      s2_item_q <= s1_item_q;
      s2_idx_q  <= s1_idx_q;
      s2_avg_q  <= old_avg;
      s2_diff_q <= diff;
      s3_item_q <= s2_item_q;
      s3_idx_q  <= s2_idx_q;
      s3_avg_q  <= s2_avg_q;
      s3_prod_q <= prod_full[48:0];
    end
    if (retire && emit) begin
      out_data_q.edge_kind   <= signal ? EDGE_RISE : EDGE_FALL;
      out_data_q.duration_ms <= s3_item_q.time_ms - last_edge_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire
